FILE: src/tte_pkg.sv
package tte_pkg;

    localparam int unsigned DIV_W = 32;

    localparam logic [31:0] OSC_NUMERATOR    = 32'h4000_0000;
    localparam int unsigned MACRO_FACTOR     = 2304;
    localparam int unsigned FACTOR_A         = 16;
    localparam int unsigned FACTOR_B         = 12;
    localparam int unsigned US_PER_MS        = 1000;
    localparam int unsigned BUDGET_OFFSET_US = 4300;
    localparam int unsigned MIN_BUDGET_MS    = 5;

    localparam logic REG_FREQ = 1'b0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK_IN,
        S_DIV_OSC,
        S_DIVISORS,
        S_CHK_DIV,
        S_DIV_A,
        S_NORM_A,
        S_DIV_B,
        S_NORM_B,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        SEL_OSC,
        SEL_A,
        SEL_B
    } t_div_sel;

    typedef struct packed {
        logic     load;
        logic     div_start;
        t_div_sel div_sel;
        logic     cap_macro;
        logic     cap_divs;
        logic     set_bad;
        logic     norm_load;
        logic     norm_shift;
        logic     store_a;
        logic     store_b;
    } t_cmd;

    typedef struct packed {
        logic bad;
        logic div_done;
        logic div_zero;
        logic norm_fit;
    } t_status;

endpackage

FILE: src/tte_div.sv
module tte_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [tte_pkg::DIV_W-1:0] i_dividend,
    input  logic [tte_pkg::DIV_W-1:0] i_divisor,
    output logic                     o_done,
    output logic [tte_pkg::DIV_W-1:0] o_quotient
);
    import tte_pkg::*;

    localparam int unsigned CNT_W = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_W - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [DIV_W-1:0] r_dsr;

    logic [DIV_W:0]   w_shift;
    logic [DIV_W:0]   w_diff;
    logic             w_ge;

    // restoring step: one quotient bit per cycle, MSB first
    assign w_shift = {r_rem, r_quo[DIV_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dsr};
    assign w_ge    = ~w_diff[DIV_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIV_W-1:0] : w_shift[DIV_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: src/tte_dp.sv
module tte_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tte_pkg::t_cmd    i_cmd,
    output tte_pkg::t_status o_status,
    input  logic [15:0]      i_freq,
    input  logic [10:0]      i_budget,
    output logic [15:0]      o_timeout_a,
    output logic [15:0]      o_timeout_b,
    output logic             o_bad_request
);
    import tte_pkg::*;

    logic [31:0] r_num;
    logic [25:0] r_macro;
    logic [25:0] r_div_a;
    logic [25:0] r_div_b;
    logic [31:0] r_norm;
    logic [4:0]  r_exp;
    logic [15:0] r_word_a;
    logic [15:0] r_word_b;
    logic        r_bad;

    logic [20:0]      w_us;
    logic [31:0]      w_macro_prod;
    logic [31:0]      w_prod_a;
    logic [31:0]      w_prod_b;
    logic [DIV_W-1:0] w_dividend;
    logic [DIV_W-1:0] w_divisor;
    logic             w_div_done;
    logic [DIV_W-1:0] w_quo;
    logic [15:0]      w_word;

    // wraps for budgets below the minimum; those requests are flagged anyway
    assign w_us = 21'(i_budget * 21'(US_PER_MS)) - 21'(BUDGET_OFFSET_US);

    assign w_macro_prod = 32'(w_quo * 32'(MACRO_FACTOR));
    assign w_prod_a     = 32'(r_macro * 32'(FACTOR_A));
    assign w_prod_b     = 32'(r_macro * 32'(FACTOR_B));

    always_comb begin
        w_dividend = OSC_NUMERATOR;
        w_divisor  = {16'h0000, i_freq};
        case (i_cmd.div_sel)
            SEL_A: begin
                w_dividend = r_num + 32'(r_div_a[25:1]);
                w_divisor  = 32'(r_div_a);
            end
            SEL_B: begin
                w_dividend = r_num + 32'(r_div_b[25:1]);
                w_divisor  = 32'(r_div_b);
            end
            default: begin
                w_dividend = OSC_NUMERATOR;
                w_divisor  = {16'h0000, i_freq};
            end
        endcase
    end

    tte_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign w_word = {3'b000, r_exp, r_norm[7:0]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_num    <= {w_us[20:1], 12'h000};
            r_bad    <= (i_freq == 16'h0000) || (i_budget < 11'(MIN_BUDGET_MS));
            r_word_a <= '0;
            r_word_b <= '0;
        end
        if (i_cmd.set_bad) begin
            r_bad <= 1'b1;
        end
        if (i_cmd.cap_macro) begin
            r_macro <= w_macro_prod[31:6];
        end
        if (i_cmd.cap_divs) begin
            r_div_a <= 26'(w_prod_a[31:6]);
            r_div_b <= 26'(w_prod_b[31:6]);
        end
        if (i_cmd.norm_load) begin
            r_norm <= (w_quo == '0) ? '0 : w_quo - 1'b1;
            r_exp  <= '0;
        end else if (i_cmd.norm_shift) begin
            r_norm <= {1'b0, r_norm[31:1]};
            r_exp  <= r_exp + 1'b1;
        end
        if (i_cmd.store_a) begin
            r_word_a <= w_word;
        end
        if (i_cmd.store_b) begin
            r_word_b <= w_word;
        end
    end

    assign o_status.bad      = r_bad;
    assign o_status.div_done = w_div_done;
    assign o_status.div_zero = (r_div_a == '0) || (r_div_b == '0);
    assign o_status.norm_fit = (r_norm[31:8] == '0);

    assign o_timeout_a   = r_word_a;
    assign o_timeout_b   = r_word_b;
    assign o_bad_request = r_bad;

endmodule

FILE: src/tte_ctrl.sv
module tte_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  tte_pkg::t_status i_status,
    output tte_pkg::t_cmd    o_cmd,
    output logic             o_busy,
    output logic             o_done
);
    import tte_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_done  = 1'b0;
        o_busy  = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHK_IN;
                end
            end
            S_CHK_IN: begin
                if (i_status.bad) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = SEL_OSC;
                    n_state         = S_DIV_OSC;
                end
            end
            S_DIV_OSC: begin
                if (i_status.div_done) begin
                    o_cmd.cap_macro = 1'b1;
                    n_state         = S_DIVISORS;
                end
            end
            S_DIVISORS: begin
                o_cmd.cap_divs = 1'b1;
                n_state        = S_CHK_DIV;
            end
            S_CHK_DIV: begin
                if (i_status.div_zero) begin
                    o_cmd.set_bad = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = SEL_A;
                    n_state         = S_DIV_A;
                end
            end
            S_DIV_A: begin
                if (i_status.div_done) begin
                    o_cmd.norm_load = 1'b1;
                    n_state         = S_NORM_A;
                end
            end
            S_NORM_A: begin
                if (i_status.norm_fit) begin
                    o_cmd.store_a   = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = SEL_B;
                    n_state         = S_DIV_B;
                end else begin
                    o_cmd.norm_shift = 1'b1;
                end
            end
            S_DIV_B: begin
                if (i_status.div_done) begin
                    o_cmd.norm_load = 1'b1;
                    n_state         = S_NORM_B;
                end
            end
            S_NORM_B: begin
                if (i_status.norm_fit) begin
                    o_cmd.store_b = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.norm_shift = 1'b1;
                end
            end
            S_DONE: begin
                o_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: src/tof_timing_budget_encoder_top.sv
// Timing-budget encoder: pulse start with i_budget while busy is low; the
// result (o_timeout_a, o_timeout_b, o_bad_request) is valid for the single
// cycle in which o_done is high and must be taken then. Three divisions
// share one restoring divider at 32 steps each (oscillator period, then
// phase A, then phase B), and each timeout word is normalized by one right
// shift per cycle, up to 24 shifts per word. A zero frequency or a budget
// under 5 ms goes from the input check straight to done, a zero divisor
// from the divisor check, both with o_bad_request set and both words zero.
// The frequency register is written over the configuration port at byte
// address 0 and should only be changed while busy is low.
module tof_timing_budget_encoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [10:0] i_budget,
    output logic        o_done,
    output logic [15:0] o_timeout_a,
    output logic [15:0] o_timeout_b,
    output logic        o_bad_request,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tte_pkg::*;

    logic [15:0] r_freq;
    logic        w_reg_idx;
    logic        w_wr;
    t_cmd        w_cmd;
    t_status     w_status;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[2];
    assign w_wr      = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq <= '0;
        end else if (w_wr && (w_reg_idx == REG_FREQ)) begin
            r_freq <= pwdata[15:0];
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_FREQ: prdata = {16'h0000, r_freq};
            default:  prdata = '0;
        endcase
    end

    tte_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy),
        .o_done   (o_done)
    );

    tte_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_freq        (r_freq),
        .i_budget      (i_budget),
        .o_timeout_a   (o_timeout_a),
        .o_timeout_b   (o_timeout_b),
        .o_bad_request (o_bad_request)
    );

`ifndef SYNTHESIS
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_bad_request |-> (o_timeout_a == 16'h0000) && (o_timeout_b == 16'h0000))
        else $error("bad request with nonzero timeout");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy && !o_done)
        else $error("controller not idle after result");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");

    a_exp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_bad_request |-> (o_timeout_a[15:8] <= 8'd24) && (o_timeout_b[15:8] <= 8'd24))
        else $error("timeout exponent out of range");
`endif

endmodule

FILE: tb/tte_timeout_checker.sv
`timescale 1ns / 1ps

module tte_timeout_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [10:0] i_budget,
    input  logic        i_done,
    input  logic [15:0] i_timeout_a,
    input  logic [15:0] i_timeout_b,
    input  logic        i_bad_request,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_fail_count,
    output int          o_pending
);
    import tte_pkg::*;

    localparam logic [2:0] FREQ_ADDR  = {REG_FREQ, 2'b00};
    localparam int         MAX_PRINTS = 100;

    typedef struct packed {
        logic [10:0] budget;
        logic [15:0] freq;
        logic [15:0] timeout_a;
        logic [15:0] timeout_b;
        logic        bad_request;
    } t_timeout_entry;

    logic [15:0]    cur_freq;
    t_timeout_entry timeout_q[$];

    // rounded quotient minus one, then exponent/mantissa normalization
    function automatic logic [15:0] encode_timeout_word(logic [31:0] num, logic [31:0] div);
        logic [31:0] quot;
        logic [7:0]  expo;
        quot = (num + (div >> 1)) / div;
        quot = (quot == 32'd0) ? 32'd0 : quot - 32'd1;
        expo = 8'd0;
        while (quot[31:8] != 24'd0) begin
            quot = quot >> 1;
            expo = expo + 8'd1;
        end
        return {expo, quot[7:0]};
    endfunction

    function automatic t_timeout_entry predict_timeouts(logic [10:0] budget, logic [15:0] freq);
        logic [31:0]    osc_period;
        logic [31:0]    scaled;
        logic [31:0]    macro_period;
        logic [31:0]    div_a;
        logic [31:0]    div_b;
        logic [31:0]    budget_num;
        t_timeout_entry e;
        e        = '0;
        e.budget = budget;
        e.freq   = freq;
        if (freq == 16'd0 || 32'(budget) < MIN_BUDGET_MS) begin
            e.bad_request = 1'b1;
            return e;
        end
        // all products wrap at 32 bits
        osc_period   = OSC_NUMERATOR / {16'd0, freq};
        scaled       = osc_period * 32'(MACRO_FACTOR);
        macro_period = scaled >> 6;
        scaled       = macro_period * 32'(FACTOR_A);
        div_a        = scaled >> 6;
        scaled       = macro_period * 32'(FACTOR_B);
        div_b        = scaled >> 6;
        if (div_a == 32'd0 || div_b == 32'd0) begin
            e.bad_request = 1'b1;
            return e;
        end
        budget_num  = 32'(budget) * 32'(US_PER_MS) - 32'(BUDGET_OFFSET_US);
        budget_num  = (budget_num >> 1) << 12;
        e.timeout_a = encode_timeout_word(budget_num, div_a);
        e.timeout_b = encode_timeout_word(budget_num, div_b);
        return e;
    endfunction

    task automatic report_mismatch(input string what, input logic [10:0] budget,
                                   input logic [15:0] freq, input logic [15:0] got,
                                   input logic [15:0] want);
        // keep the log short on a badly broken block, but count everything
        if (o_fail_count < MAX_PRINTS)
            $display("%0t: %s mismatch, budget %0d ms, freq %0d: got %h, want %h",
                     $time, what, budget, freq, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin : track_results
        t_timeout_entry want;
        if (!i_rst_n) begin
            cur_freq = 16'd0;
            timeout_q.delete();
            o_fail_count = 0;
            o_pending    = 0;
        end else begin
            // a request taken at this edge still sees the old frequency
            if (i_start && !i_busy)
                timeout_q.push_back(predict_timeouts(i_budget, cur_freq));
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == FREQ_ADDR)
                cur_freq = i_pwdata[15:0];
            if (i_done) begin
                if (timeout_q.size() == 0) begin
                    report_mismatch("unrequested result", 11'd0, cur_freq, i_timeout_a, 16'd0);
                end else begin
                    want = timeout_q.pop_front();
                    if (i_bad_request !== want.bad_request)
                        report_mismatch("bad_request", want.budget, want.freq,
                                        16'(i_bad_request), 16'(want.bad_request));
                    if (i_timeout_a !== want.timeout_a)
                        report_mismatch("timeout_a", want.budget, want.freq,
                                        i_timeout_a, want.timeout_a);
                    if (i_timeout_b !== want.timeout_b)
                        report_mismatch("timeout_b", want.budget, want.freq,
                                        i_timeout_b, want.timeout_b);
                end
            end
            o_pending = timeout_q.size();
        end
    end

endmodule

FILE: tb/tb_tof_timing_budget_encoder_top.sv
`timescale 1ns / 1ps

module tb_tof_timing_budget_encoder_top;
    import tte_pkg::*;

    localparam int         RANDOM_PHASES  = 10;
    localparam int         PHASE_ITEMS    = 113;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         SETTLE_CYCLES  = 200;
    localparam logic [2:0] FREQ_ADDR      = {REG_FREQ, 2'b00};

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        start      = 1'b0;
    logic [10:0] req_budget = '0;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [2:0]  paddr      = '0;
    logic [31:0] pwdata     = '0;
    logic        busy;
    logic        done;
    logic [15:0] timeout_a;
    logic [15:0] timeout_b;
    logic        bad_request;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending_count;
    int          idle_cycles = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    tof_timing_budget_encoder_top u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .start         (start),
        .busy          (busy),
        .i_budget      (req_budget),
        .o_done        (done),
        .o_timeout_a   (timeout_a),
        .o_timeout_b   (timeout_b),
        .o_bad_request (bad_request),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    tte_timeout_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_budget      (req_budget),
        .i_done        (done),
        .i_timeout_a   (timeout_a),
        .i_timeout_b   (timeout_b),
        .i_bad_request (bad_request),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_pready      (pready),
        .o_fail_count  (fail_count),
        .o_pending     (pending_count)
    );

    // an accepted request, a result or a register write resets the count
    always @(posedge clk) begin
        if (rst_n) begin
            if ((start && !busy) || done || (psel && penable && pwrite && pready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // returns at the edge that takes the transfer; start is left high
    task automatic send_budget(input logic [10:0] b);
        start      <= 1'b1;
        req_budget <= b;
        @(negedge clk);
        while (busy) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic pause_idle(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(negedge clk);
        while (pending_count != 0 || busy) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_freq_reg(input logic [15:0] f);
        drain_results();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= FREQ_ADDR;
        pwdata  <= {16'd0, f};
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        while (!pready) @(negedge clk);
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [10:0] random_budget();
        case ($urandom_range(0, 19))
            0:       return 11'($urandom_range(0, 4));
            1:       return 11'($urandom_range(2001, 2047));
            2:       return 11'($urandom);
            default: return 11'($urandom_range(5, 2000));
        endcase
    endfunction

    function automatic logic [15:0] pick_phase_freq(input int p);
        case (p)
            0:       return 16'hFFFF;
            1:       return 16'($urandom_range(1, 63));
            2:       return 16'd0;
            default: begin
                if ($urandom_range(0, 3) == 0)
                    return 16'($urandom_range(1, 1023));
                return 16'($urandom_range(1, 65535));
            end
        endcase
    endfunction

    initial begin
        int sent;
        int burst;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // frequency still zero from reset
        send_budget(11'd0);
        send_budget(11'd2047);
        send_budget(11'd300);

        write_freq_reg(16'd200);
        send_budget(11'd0);
        send_budget(11'd4);
        send_budget(11'd5);
        send_budget(11'd6);
        send_budget(11'd33);
        send_budget(11'd1000);
        send_budget(11'd2000);
        send_budget(11'd2047);
        send_budget(11'h555);
        send_budget(11'h2AA);

        // macro period wraps to zero, so the divisors are zero
        write_freq_reg(16'd1);
        send_budget(11'd50);

        // large divisors: the shortest budget rounds to a zero quotient
        write_freq_reg(16'd577);
        send_budget(11'd5);
        send_budget(11'd20);

        write_freq_reg(16'hFFFF);
        send_budget(11'd5);
        send_budget(11'd1024);
        send_budget(11'd2047);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_freq_reg(pick_phase_freq(p));
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                burst = $urandom_range(1, 16);
                for (int i = 0; i < burst && sent < PHASE_ITEMS; i++) begin
                    send_budget(random_budget());
                    sent++;
                end
                // no pause at all keeps start high across bursts
                if ($urandom_range(0, 11) == 0)
                    drain_results();
                else if ($urandom_range(0, 3) != 0)
                    pause_idle($urandom_range(1, 180));
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
